// ===== hdl/ldq_pkg.sv =====
// Shared types, register codes and constants for the landing detector qualifier.
// Used by ldq_criteria and landing_detector_qualifier; depends on nothing else.
package ldq_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_TRIGGER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AIRMODE_TRIGGER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAYBE_TRIGGER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX_SQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN_ALT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NON_TAKEOFF_THR = 3'd5;

    localparam int CFG_DATA_W = 22;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    // Register values after reset.
    localparam logic [15:0] LAND_TRIGGER_RST    = 16'd400;
    localparam logic [15:0] AIRMODE_TRIGGER_RST = 16'd1200;
    localparam logic [15:0] MAYBE_TRIGGER_RST   = 16'd80;
    localparam logic [21:0] ACCEL_MAX_SQ_RST    = 22'd10000;
    localparam logic [15:0] RANGE_MIN_ALT_RST   = 16'd200;
    localparam logic [9:0]  NON_TAKEOFF_THR_RST = 10'd250;

    // Climb rate limit in cm/s with no wheel sensor; doubled with one.
    localparam logic [16:0] CLIMB_LIMIT_CMS = 17'd100;

    // Weight-on-wheels codes.
    localparam logic [1:0] WOW_UNKNOWN   = 2'd0;
    localparam logic [1:0] WOW_ON_GROUND = 2'd1;

    typedef struct packed {
        logic        armed;
        logic        standby;
        logic        taking_off;
        logic        spool_unlimited;
        logic [9:0]  throttle_out;
        logic        throttle_at_lower_limit;
        logic        mix_at_floor;
        logic        manual_airmode;
        logic [23:0] accel_len_sq;
        logic signed [15:0] climb_rate_cms;
        logic signed [16:0] range_alt_cm;
        logic [1:0]  wow_state;
    } ldq_item_t;

    typedef struct packed {
        logic [15:0] land_trigger_ticks;
        logic [15:0] airmode_trigger_ticks;
        logic [15:0] maybe_trigger_ticks;
        logic [21:0] accel_max_sq;
        logic [15:0] range_min_alt_cm;
        logic [9:0]  non_takeoff_throttle;
    } ldq_cfg_t;

    // Outcome of the landing criteria check for one tick.
    typedef struct packed {
        logic        all_met;
        logic [15:0] trigger;
    } ldq_crit_t;

endpackage

// ===== hdl/ldq_criteria.sv =====
// Landing criteria check for one tick: the six ground tests and the trigger choice.
// Depends on ldq_pkg.
module ldq_criteria
    import ldq_pkg::*;
(
    input  ldq_item_t item,
    input  ldq_cfg_t  cfg,
    output ldq_crit_t crit
);

    logic        wheel_known;
    logic [23:0] accel_limit;
    logic [16:0] climb_abs;
    logic [16:0] climb_limit;
    logic        accel_ok;
    logic        climb_ok;
    logic        range_ok;
    logic        wow_ok;
    logic        mix_ok;

    // A known wheel sensor loosens the acceleration limit by four and the climb limit by two.
    assign wheel_known = (item.wow_state != WOW_UNKNOWN);
    assign accel_limit = wheel_known ? {cfg.accel_max_sq, 2'b00} : {2'b00, cfg.accel_max_sq};
    assign accel_ok    = (item.accel_len_sq <= accel_limit);

    assign climb_abs   = item.climb_rate_cms[15] ?
                         (17'd0 - {1'b1, item.climb_rate_cms}) :
                         {1'b0, item.climb_rate_cms};
    assign climb_limit = wheel_known ? {CLIMB_LIMIT_CMS[15:0], 1'b0} : CLIMB_LIMIT_CMS;
    assign climb_ok    = (climb_abs < climb_limit);

    // Any negative altitude means the rangefinder is not healthy.
    assign range_ok = item.range_alt_cm[16] ||
                      (item.range_alt_cm[15:0] < cfg.range_min_alt_cm);
    assign wow_ok   = (item.wow_state == WOW_UNKNOWN) || (item.wow_state == WOW_ON_GROUND);
    assign mix_ok   = item.mix_at_floor || item.manual_airmode;

    assign crit.all_met = item.throttle_at_lower_limit && mix_ok && accel_ok &&
                          climb_ok && range_ok && wow_ok;
    assign crit.trigger = item.manual_airmode ? cfg.airmode_trigger_ticks :
                                                cfg.land_trigger_ticks;

endmodule

// ===== hdl/landing_detector_qualifier.sv =====
// Top level of the landing detector qualifier: register file, landed state and result buffer.
// Depends on ldq_pkg and ldq_criteria.
//
//  Channel   Handshake             Payload
//  s_*       s_tvalid / s_tready   s_tdata[79:0]: one control-loop tick
//  m_*       m_tvalid / m_tready   m_tdata[7:0]: landed status after the tick
//  cfg_*     cfg_wr_en             cfg_index, cfg_data: register write
//
// Each request is processed in the cycle it is accepted: the criteria logic reads the
// input word and the state registers, and the landed flag, counter and result register
// load at the same edge, so one tick is taken every cycle while s_tready is high. Reset
// clears the landed flag, the counter and both result slots, and restores the register
// defaults. When m_tready is held low, a second result lands in a skid register and
// s_tready drops only once that register is full.
module landing_detector_qualifier
    import ldq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // armed[0], standby[1], taking_off[2], spool_unlimited[3], throttle_out[13:4],
    // throttle_at_lower_limit[14], mix_at_floor[15], manual_airmode[16],
    // accel_len_sq[40:17], climb_rate_cms[56:41], range_alt_cm[73:57],
    // wow_state[75:74], zero fill[79:76]
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // landed_now[0], land_maybe[1], became_landed[2], became_airborne[3],
    // zero fill[7:4]
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ldq_cfg_t   cfg_reg;
    ldq_item_t  item;
    ldq_crit_t  crit;

    logic        landed_reg;
    logic        landed_next;
    logic [15:0] persist_count_reg;
    logic [15:0] persist_count_next;
    logic        maybe_next;
    logic [3:0]  result_next;

    logic [3:0]  out_reg;
    logic        out_valid_reg;
    logic [3:0]  skid_reg;
    logic        skid_valid_reg;

    logic        accept;
    logic        pop;

    // Unpack the request word into its fields.
    assign item.armed                   = s_tdata[0];
    assign item.standby                 = s_tdata[1];
    assign item.taking_off              = s_tdata[2];
    assign item.spool_unlimited         = s_tdata[3];
    assign item.throttle_out            = s_tdata[13:4];
    assign item.throttle_at_lower_limit = s_tdata[14];
    assign item.mix_at_floor            = s_tdata[15];
    assign item.manual_airmode          = s_tdata[16];
    assign item.accel_len_sq            = s_tdata[40:17];
    assign item.climb_rate_cms          = s_tdata[56:41];
    assign item.range_alt_cm            = s_tdata[73:57];
    assign item.wow_state               = s_tdata[75:74];

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.land_trigger_ticks    <= LAND_TRIGGER_RST;
            cfg_reg.airmode_trigger_ticks <= AIRMODE_TRIGGER_RST;
            cfg_reg.maybe_trigger_ticks   <= MAYBE_TRIGGER_RST;
            cfg_reg.accel_max_sq          <= ACCEL_MAX_SQ_RST;
            cfg_reg.range_min_alt_cm      <= RANGE_MIN_ALT_RST;
            cfg_reg.non_takeoff_throttle  <= NON_TAKEOFF_THR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LAND_TRIGGER:    cfg_reg.land_trigger_ticks    <= cfg_data[15:0];
                REG_AIRMODE_TRIGGER: cfg_reg.airmode_trigger_ticks <= cfg_data[15:0];
                REG_MAYBE_TRIGGER:   cfg_reg.maybe_trigger_ticks   <= cfg_data[15:0];
                REG_ACCEL_MAX_SQ:    cfg_reg.accel_max_sq          <= cfg_data;
                REG_RANGE_MIN_ALT:   cfg_reg.range_min_alt_cm      <= cfg_data[15:0];
                REG_NON_TAKEOFF_THR: cfg_reg.non_takeoff_throttle  <= cfg_data[9:0];
                default:             ;
            endcase
        end
    end

    ldq_criteria u_criteria
    (
        .item (item),
        .cfg  (cfg_reg),
        .crit (crit)
    );

    // Landed state update. A disarmed vehicle is landed. A landed vehicle goes airborne
    // once throttle rises past the takeoff limit with the spool unlimited and taking_off
    // low. An airborne vehicle counts qualifying ticks and declares landing once the
    // trigger is reached. Every change of the landed flag clears the counter.
    always_comb
    begin
        landed_next        = landed_reg;
        persist_count_next = persist_count_reg;
        if (!item.armed)
        begin
            landed_next = 1'b1;
            if (!landed_reg)
            begin
                persist_count_next = '0;
            end
        end
        else if (landed_reg)
        begin
            if (!item.taking_off && item.spool_unlimited &&
                (item.throttle_out > cfg_reg.non_takeoff_throttle))
            begin
                landed_next        = 1'b0;
                persist_count_next = '0;
            end
        end
        else if (item.standby)
        begin
            persist_count_next = '0;
        end
        else if (crit.all_met)
        begin
            if (persist_count_reg < crit.trigger)
            begin
                persist_count_next = persist_count_reg + 16'd1;
            end
            else
            begin
                landed_next        = 1'b1;
                persist_count_next = '0;
            end
        end
        else
        begin
            persist_count_next = '0;
        end
        maybe_next  = landed_next || (persist_count_next >= cfg_reg.maybe_trigger_ticks);
        result_next = {landed_reg && !landed_next, !landed_reg && landed_next,
                       maybe_next, landed_next};
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landed_reg        <= 1'b0;
            persist_count_reg <= '0;
        end
        else if (accept)
        begin
            landed_reg        <= landed_next;
            persist_count_reg <= persist_count_next;
        end
    end

    // Two-slot result buffer: the output register and a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && out_valid_reg && !pop)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && out_valid_reg && !pop)
        begin
            skid_reg <= result_next;
        end
        else if (accept)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-4){1'b0}}, out_reg};

    // The skid slot only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output register empty");

    // A result never reports both a landing and a takeoff.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("result reports landing and takeoff at once");

    // A landed result is always a maybe result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("landed result without maybe");

    // A disarmed request leaves the vehicle landed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.armed) |=> landed_reg)
        else $error("disarmed request did not set the landed flag");

    // Any change of the landed flag clears the counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (landed_reg != $past(landed_reg)) |-> (persist_count_reg == 16'd0))
        else $error("counter not cleared on a landed flag change");

endmodule
